// ===== rtl/core/esort_pkg.sv =====
package esort_pkg;

    // Width of one element of the set
    localparam int DATA_W = 16;

    typedef logic [DATA_W-1:0] elem_t;

endpackage

// ===== rtl/core/esort_mem.sv =====
module esort_mem
    import esort_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  elem_t         wdata,
    input  logic [AW-1:0] raddr,
    output elem_t         rdata
);

    elem_t mem [DEPTH];
    elem_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/esort_ctrl.sv =====
module esort_ctrl
    import esort_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  elem_t         s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output elem_t         m_tdata,
    output logic          m_tlast,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output elem_t         ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  elem_t         ram_rdata
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RDI   = 3'd1;
    localparam logic [2:0] ST_CURI  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_WBI   = 3'd4;
    localparam logic [2:0] ST_EMRD  = 3'd5;
    localparam logic [2:0] ST_EMCAP = 3'd6;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    elem_t         cur_reg, cur_next;
    elem_t         out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_valid_reg, out_valid_next;

    logic          in_fire;
    logic          full;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] raddr;
    logic [CW-1:0] waddr;

    assign in_fire = s_tvalid && s_tready;
    assign full    = (cnt_reg == CAP_C);
    assign n_eff   = full ? cnt_reg : cnt_reg + ONE_C;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        waddr          = cnt_reg;
        ram_wdata      = s_tdata;
        raddr          = i_reg;

        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (in_fire) begin
                    // store unless full; a closing beat still closes the set
                    if (!full) begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + ONE_C;
                    end
                    if (s_tlast) begin
                        i_next     = '0;
                        state_next = (n_eff >= TWO_C) ? ST_RDI : ST_EMRD;
                    end
                end
            end
            ST_RDI: begin
                raddr      = i_reg;
                state_next = ST_CURI;
            end
            ST_CURI: begin
                cur_next   = ram_rdata;
                raddr      = i_reg + ONE_C;
                j_next     = i_reg + ONE_C;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // hold element i in cur_reg; swap it with j when smaller
                if (cur_reg < ram_rdata) begin
                    ram_we    = 1'b1;
                    waddr     = j_reg;
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                raddr = j_reg + ONE_C;
                if (j_reg + ONE_C < cnt_reg) begin
                    j_next = j_reg + ONE_C;
                end else begin
                    state_next = ST_WBI;
                end
            end
            ST_WBI: begin
                ram_we    = 1'b1;
                waddr     = i_reg;
                ram_wdata = cur_reg;
                if (i_reg + TWO_C < cnt_reg) begin
                    i_next     = i_reg + ONE_C;
                    state_next = ST_RDI;
                end else begin
                    i_next     = '0;
                    state_next = ST_EMRD;
                end
            end
            ST_EMRD: begin
                raddr = i_reg;
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_EMCAP;
                end
            end
            ST_EMCAP: begin
                out_data_next  = ram_rdata;
                out_valid_next = 1'b1;
                out_last_next  = (i_reg + ONE_C == cnt_reg);
                if (i_reg + ONE_C == cnt_reg) begin
                    cnt_next   = '0;
                    i_next     = '0;
                    state_next = ST_LOAD;
                end else begin
                    i_next     = i_reg + ONE_C;
                    state_next = ST_EMRD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign ram_raddr = raddr[AW-1:0];
    assign ram_waddr = waddr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP_C)
        else $error("element count beyond capacity");

    a_close_leaves_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> !s_tready)
        else $error("closing beat did not start sort or emit");

    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMCAP) |-> (i_reg < cnt_reg))
        else $error("emit index past loaded count");

    a_out_from_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMCAP))
        else $error("output register loaded outside capture");

endmodule

// ===== rtl/core/descending_exchange_sort.sv =====
// Channel   Dir  Handshake          Payload (low bit up)
// s_        in   s_tvalid/s_tready  s_tdata[15:0] value, s_tlast is_last
// m_        out  m_tvalid/m_tready  m_tdata[15:0] sorted_value, m_tlast end_of_set
//
// Loading accepts one beat per cycle. After the closing beat the set of n elements
// is sorted in the element RAM: for each outer position i, element i is read,
// captured, compared with each later element in turn and written back, through
// the single read port of the RAM. Each result is read, then captured for output.
// aresetn is synchronous, active low; the RAM contents are not cleared.
// Input is held off (s_tready low) from the closing beat until the last result
// is captured into the output register; a stalled result holds the emit sequence.
module descending_exchange_sort
    import esort_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [15:0] value
    input  logic              s_tlast,   // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [15:0] sorted_value
    output logic              m_tlast    // end_of_set
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    elem_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    elem_t         ram_rdata;

    // sequencer: load, exchange sort, emit
    esort_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // element store, one write and one registered read per cycle
    esort_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import esort_pkg::*;

    localparam int SET_CAP = 64;

    // One beat waiting to go into the sorter; hold_for_drain keeps it back
    // until every sorted beat of earlier sets has come out.
    typedef struct {
        elem_t value;
        bit    last;
        bit    hold_for_drain;
    } load_beat_t;

    // One sorted beat as it should leave the block
    typedef struct {
        elem_t value;
        bit    end_of_set;
    } sorted_beat_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [15:0] value
    logic              s_tlast  = 1'b0; // is_last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [15:0] sorted_value
    logic              m_tlast;         // end_of_set

    load_beat_t   load_queue[$];
    sorted_beat_t sorted_expect[$];
    elem_t        held_set[$];
    int           beats_loaded = 0;
    int           fail_count   = 0;
    bit           steady;

    descending_exchange_sort #(
        .CAPACITY(SET_CAP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Stretch of the run with no idling on either side
    assign steady = (beats_loaded >= 130) && (beats_loaded < 190);

    // Track the set being loaded. Drop beats past capacity, but let a dropped
    // closing beat still close the set. On close, exchange sort the held
    // elements largest first and queue one expected beat per element.
    task automatic take_load_beat(input elem_t value, input bit last);
        elem_t sort_buf[];
        elem_t swap_tmp;
        int    n;
        if (held_set.size() < SET_CAP) begin
            held_set.push_back(value);
        end
        if (last) begin
            n = held_set.size();
            sort_buf = new[n];
            foreach (held_set[k]) sort_buf[k] = held_set[k];
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    if (sort_buf[i] < sort_buf[j]) begin
                        swap_tmp    = sort_buf[i];
                        sort_buf[i] = sort_buf[j];
                        sort_buf[j] = swap_tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                sorted_expect.push_back('{value: sort_buf[k], end_of_set: (k == n - 1)});
            end
            held_set.delete();
        end
    endtask

    // Driver: advance the load queue on each accepted beat, keep a stalled beat
    // stable, and otherwise present the next beat unless idling or held off.
    always @(posedge aclk) begin
        bit go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_load_beat(load_queue[0].value, load_queue[0].last);
                void'(load_queue.pop_front());
                beats_loaded++;
            end
            if (!(s_tvalid && !s_tready)) begin
                go = load_queue.size() > 0;
                if (go && load_queue[0].hold_for_drain && sorted_expect.size() > 0) begin
                    go = 1'b0;
                end
                if (go && !steady && $urandom_range(99) < 27) begin
                    go = 1'b0;
                end
                s_tvalid <= go;
                if (go) begin
                    s_tdata <= load_queue[0].value;
                    s_tlast <= load_queue[0].last;
                end
            end
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation,
    // then stall the result side at random.
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sorted_expect.size() == 0) begin
                    $error("result beat with nothing expected: sorted_value %h end_of_set %b",
                           m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = sorted_expect.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("sorted_value mismatch: expected %h, got %h",
                               want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.end_of_set) begin
                        $error("end_of_set mismatch: expected %b, got %b",
                               want.end_of_set, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 27);
        end
    end

    task automatic queue_beat(input elem_t value, input bit last, input bit hold = 1'b0);
        load_queue.push_back('{value: value, last: last, hold_for_drain: hold});
    endtask

    // Queue one random set of n beats; the closing flag goes on the final beat
    // even when that beat lands past capacity and gets dropped.
    task automatic queue_random_set(input int n, input bit hold);
        int    shape;
        elem_t base;
        elem_t v;
        shape = $urandom_range(3);
        base  = elem_t'($urandom_range(16'hFFFF));
        for (int k = 0; k < n; k++) begin
            case (shape)
                0: v = ($urandom_range(7) == 0) ? 16'hFFFF : elem_t'($urandom_range(3));
                1: v = base + elem_t'(k);
                default: v = elem_t'($urandom_range(16'hFFFF));
            endcase
            queue_beat(v, k == n - 1, hold && k == 0);
        end
    endtask

    // Ceiling on the run: far beyond the slowest legal sort and drain
    initial begin
        #2_000_000;
        $display("descending_exchange_sort verification failed");
        $finish;
    end

    initial begin
        int set_len;
        // Single-element sets at both extremes
        queue_beat(16'h0000, 1'b1);
        queue_beat(16'hFFFF, 1'b1);
        // Pairs in both orders
        queue_beat(16'h0000, 1'b0);
        queue_beat(16'hFFFF, 1'b1);
        queue_beat(16'hFFFF, 1'b0, 1'b1);
        queue_beat(16'h0000, 1'b1);
        // All equal
        repeat (3) queue_beat(16'h1234, 1'b0);
        queue_beat(16'h1234, 1'b1);
        // Mixed bit patterns
        queue_beat(16'h8000, 1'b0);
        queue_beat(16'h7FFF, 1'b0);
        queue_beat(16'h0001, 1'b0);
        queue_beat(16'hFFFE, 1'b0);
        queue_beat(16'h5555, 1'b0);
        queue_beat(16'hAAAA, 1'b1);
        // Already ascending, the worst order for this sort
        for (int k = 0; k < 5; k++) queue_beat(elem_t'(16'h0100 * k), k == 4);

        // Exactly full, then an overflow whose closing beat is dropped
        queue_random_set(SET_CAP, 1'b1);
        queue_random_set(SET_CAP + 2, 1'b0);

        while (load_queue.size() < 250) begin
            if ($urandom_range(29) == 0) begin
                set_len = SET_CAP - 1 + int'($urandom_range(3));
            end else begin
                set_len = int'($urandom_range(1, 8));
            end
            queue_random_set(set_len, $urandom_range(19) == 0);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (load_queue.size() == 0 && !s_tvalid);
        wait (sorted_expect.size() == 0);
        repeat (50) @(posedge aclk);

        if (fail_count == 0) begin
            $display("descending_exchange_sort verification clean");
        end else begin
            $display("descending_exchange_sort verification failed");
        end
        $finish;
    end

endmodule
